FILE: rtl/core/sdp_pkg.sv
// Package for the SIP distortion polynomial unit: sizes, codes, constants
// and the command type shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdp_pkg;

  // Table geometry
  localparam int MAX_ORDER = 7;
  localparam int DIM       = MAX_ORDER + 1;
  localparam int IDX_W     = $clog2(DIM);
  localparam int TBL_W     = 2;
  localparam int ADDR_W    = TBL_W + 2 * IDX_W;
  localparam int DEPTH     = 1 << ADDR_W;

  // Fixed field widths
  localparam int ORDER_W = 3;
  localparam int CFG_W   = 3;

  // Item operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FWD   = 2'd1;
  localparam logic [1:0] OP_REV   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] CFG_REF_X = 3'd0;
  localparam logic [CFG_W-1:0] CFG_REF_Y = 3'd1;
  localparam logic [CFG_W-1:0] CFG_FWD_X = 3'd2;
  localparam logic [CFG_W-1:0] CFG_FWD_Y = 3'd3;
  localparam logic [CFG_W-1:0] CFG_REV_X = 3'd4;
  localparam logic [CFG_W-1:0] CFG_REV_Y = 3'd5;

  // Floating point unit operations
  localparam logic [1:0] FOP_ADD = 2'd0;
  localparam logic [1:0] FOP_SUB = 2'd1;
  localparam logic [1:0] FOP_MUL = 2'd2;

  // Sequencer steps
  localparam logic [2:0] ST_U   = 3'd0;  // u = x - ref_x
  localparam logic [2:0] ST_V   = 3'd1;  // v = y - ref_y
  localparam logic [2:0] ST_PU  = 3'd2;  // u power
  localparam logic [2:0] ST_PV  = 3'd3;  // v power
  localparam logic [2:0] ST_MC  = 3'd4;  // coef * u^i
  localparam logic [2:0] ST_MV  = 3'd5;  // term * v^j
  localparam logic [2:0] ST_ACC = 3'd6;  // acc + term
  localparam logic [2:0] ST_FIN = 3'd7;  // coordinate + acc

  // Binary64 constants
  localparam logic [63:0] FP_ONE    = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FP_DNAN   = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FP_QUIET  = 64'h0008_0000_0000_0000;

  // Command from the controller to the datapath
  typedef struct packed {
    logic             start;
    logic [2:0]       step;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             dir;
    logic             tbl;
    logic             acc_clr;
    logic             out_load;
  } sdp_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/sdp_ifs.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface sdp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  table_select;
  logic [2:0]  power_of_u;
  logic [2:0]  power_of_v;
  logic [63:0] coef_value;
  logic [63:0] x_in;
  logic [63:0] y_in;

  modport source(output valid, operation, table_select, power_of_u, power_of_v,
                 coef_value, x_in, y_in, input ready);
  modport sink(input valid, operation, table_select, power_of_u, power_of_v,
               coef_value, x_in, y_in, output ready);
endinterface

interface sdp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] x_out;
  logic [63:0] y_out;

  modport source(output valid, x_out, y_out, input ready);
  modport sink(input valid, x_out, y_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sdp_fpu.sv
// Multi-cycle binary64 add, subtract and multiply, round to nearest even.
// Depends on sdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdp_fpu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [1:0]  fop,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      res
);
  import sdp_pkg::*;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_CLASS = 3'd1;
  localparam logic [2:0] F_MUL   = 3'd2;
  localparam logic [2:0] F_ALIGN = 3'd3;
  localparam logic [2:0] F_ADD   = 3'd4;
  localparam logic [2:0] F_NORM  = 3'd5;
  localparam logic [2:0] F_DEN   = 3'd6;
  localparam logic [2:0] F_RND   = 3'd7;

  logic [2:0]          st_r;
  logic [1:0]          op_r;
  logic [63:0]         a_r, b_r, res_r;
  logic                done_r;
  logic                sign_r, sub_r, den_r;
  logic signed [13:0]  exp_r, bexp_r;
  logic [127:0]        wide_r, big_r, small_r;
  logic [10:0]         ebig_r, esml_r;
  logic [52:0]         ma_r, mb_r;
  logic [2:0]          cnt_r;
  logic [53:0]         prod_r;
  logic [1:0]          pn_r;
  logic [105:0]        acc_r;

  // Operand classification
  logic        sa, sbe, sm;
  logic [10:0] xa, xb, ea, eb;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_ge_b;
  logic [52:0] mant_a, mant_b;

  always_comb begin
    sa     = a_r[63];
    sbe    = b_r[63] ^ (op_r == FOP_SUB);
    sm     = a_r[63] ^ b_r[63];
    xa     = a_r[62:52];
    xb     = b_r[62:52];
    fa     = a_r[51:0];
    fb     = b_r[51:0];
    a_nan  = (&xa) && (|fa);
    b_nan  = (&xb) && (|fb);
    a_inf  = (&xa) && !(|fa);
    b_inf  = (&xb) && !(|fb);
    a_zero = (xa == 11'd0) && (fa == 52'd0);
    b_zero = (xb == 11'd0) && (fb == 52'd0);
    ea     = (xa == 11'd0) ? 11'd1 : xa;
    eb     = (xb == 11'd0) ? 11'd1 : xb;
    mant_a = {|xa, fa};
    mant_b = {|xb, fb};
    a_ge_b = a_r[62:0] >= b_r[62:0];
  end

  // Partial product selection and accumulation
  logic [26:0]  pa, pb;
  logic [105:0] pp_sh, acc_sum;
  logic [1:0]   pn_nxt;

  always_comb begin
    pa     = cnt_r[1] ? ma_r[52:26] : {1'b0, ma_r[25:0]};
    pb     = cnt_r[0] ? mb_r[52:26] : {1'b0, mb_r[25:0]};
    pn_nxt = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    case (pn_r)
      2'd0:    pp_sh = 106'(prod_r);
      2'd1:    pp_sh = 106'(prod_r) << 26;
      default: pp_sh = 106'(prod_r) << 52;
    endcase
    acc_sum = acc_r + pp_sh;
  end

  // Alignment, add and subnormal shift
  logic [10:0]        dsh;
  logic [127:0]       amask, sum;
  logic               ast;
  logic signed [13:0] bexp_n, dsub;
  logic [127:0]       dmask;
  logic               dst;

  always_comb begin
    dsh    = ebig_r - esml_r;
    amask  = (128'd1 << dsh) - 128'd1;
    ast    = |(small_r & amask);
    sum    = sub_r ? (big_r - small_r) : (big_r + small_r);
    bexp_n = exp_r + 14'sd1150;
    dsub   = 14'sd1 - bexp_n;
    dmask  = (128'd1 << $unsigned(dsub)) - 128'd1;
    dst    = |(wide_r & dmask);
  end

  // Rounding
  logic [10:0] expf;
  logic        rup;

  always_comb begin
    expf = den_r ? 11'd0 : bexp_r[10:0];
    rup  = wide_r[74] & ((|wide_r[73:0]) | wide_r[75]);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        F_IDLE: if (start) st_r <= F_CLASS;
        F_CLASS: begin
          if (a_nan || b_nan) begin
            st_r <= F_IDLE; done_r <= 1'b1;
          end else if (op_r == FOP_MUL) begin
            if (a_inf || b_inf || a_zero || b_zero) begin
              st_r <= F_IDLE; done_r <= 1'b1;
            end else begin
              st_r <= F_MUL;
            end
          end else if (a_inf || b_inf || a_zero || b_zero) begin
            st_r <= F_IDLE; done_r <= 1'b1;
          end else begin
            st_r <= F_ALIGN;
          end
        end
        F_MUL:   if (cnt_r == 3'd4) st_r <= F_NORM;
        F_ALIGN: st_r <= F_ADD;
        F_ADD: begin
          if (sum == 128'd0) begin
            st_r <= F_IDLE; done_r <= 1'b1;
          end else begin
            st_r <= F_NORM;
          end
        end
        F_NORM:  if (wide_r[127]) st_r <= F_DEN;
        F_DEN:   st_r <= F_RND;
        F_RND: begin
          st_r <= F_IDLE; done_r <= 1'b1;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      F_IDLE: begin
        if (start) begin
          op_r <= fop;
          a_r  <= a;
          b_r  <= b;
        end
      end
      F_CLASS: begin
        cnt_r <= 3'd0;
        acc_r <= 106'd0;
        if (a_nan) begin
          res_r <= a_r | FP_QUIET;
        end else if (b_nan) begin
          res_r <= b_r | FP_QUIET;
        end else if (op_r == FOP_MUL) begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            res_r <= FP_DNAN;
          end else if (a_inf || b_inf) begin
            res_r <= {sm, 11'h7FF, 52'd0};
          end else if (a_zero || b_zero) begin
            res_r <= {sm, 63'd0};
          end
          ma_r   <= mant_a;
          mb_r   <= mant_b;
          sign_r <= sm;
          exp_r  <= $signed({3'b000, ea}) + $signed({3'b000, eb}) - 14'sd2172;
        end else begin
          if (a_inf && b_inf && (sa != sbe)) begin
            res_r <= FP_DNAN;
          end else if (a_inf) begin
            res_r <= a_r;
          end else if (b_inf) begin
            res_r <= {sbe, b_r[62:0]};
          end else if (a_zero && b_zero) begin
            res_r <= {sa & sbe, 63'd0};
          end else if (b_zero) begin
            res_r <= a_r;
          end else if (a_zero) begin
            res_r <= {sbe, b_r[62:0]};
          end
          sub_r <= sa != sbe;
          if (a_ge_b) begin
            big_r   <= {1'b0, mant_a, 74'd0};
            small_r <= {1'b0, mant_b, 74'd0};
            ebig_r  <= ea;
            esml_r  <= eb;
            sign_r  <= sa;
            exp_r   <= $signed({3'b000, ea}) - 14'sd1149;
          end else begin
            big_r   <= {1'b0, mant_b, 74'd0};
            small_r <= {1'b0, mant_a, 74'd0};
            ebig_r  <= eb;
            esml_r  <= ea;
            sign_r  <= sbe;
            exp_r   <= $signed({3'b000, eb}) - 14'sd1149;
          end
        end
      end
      F_MUL: begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r != 3'd4) begin
          prod_r <= pa * pb;
          pn_r   <= pn_nxt;
        end
        if (cnt_r != 3'd0) acc_r <= acc_sum;
        if (cnt_r == 3'd4) wide_r <= {acc_sum, 22'd0};
      end
      F_ALIGN: small_r <= (small_r >> dsh) | {127'd0, ast};
      F_ADD: begin
        wide_r <= sum;
        if (sum == 128'd0) res_r <= 64'd0;
      end
      F_NORM: begin
        if (!wide_r[127]) begin
          if (wide_r[127:120] == 8'd0) begin
            wide_r <= wide_r << 8;
            exp_r  <= exp_r - 14'sd8;
          end else begin
            wide_r <= wide_r << 1;
            exp_r  <= exp_r - 14'sd1;
          end
        end
      end
      F_DEN: begin
        bexp_r <= bexp_n;
        if (bexp_n < 14'sd1) begin
          den_r  <= 1'b1;
          wide_r <= (wide_r >> $unsigned(dsub)) | {127'd0, dst};
        end else begin
          den_r <= 1'b0;
        end
      end
      F_RND: begin
        if (!den_r && (bexp_r >= 14'sd2047)) begin
          res_r <= {sign_r, 11'h7FF, 52'd0};
        end else begin
          res_r <= {sign_r, {expf, wide_r[126:75]} + {62'd0, rup}};
        end
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

FILE: rtl/core/sdp_dpath.sv
// Datapath: coefficient memory, operand and power registers, shared
// floating point unit and result registers. Depends on sdp_pkg, sdp_fpu.
`timescale 1ns / 1ps
`default_nettype none
module sdp_dpath (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [sdp_pkg::CFG_W-1:0] cfg_index,
  input  wire logic [63:0]            cfg_data,
  input  wire logic                   in_fire,
  input  wire logic [1:0]             in_operation,
  input  wire logic [1:0]             in_table_select,
  input  wire logic [2:0]             in_power_of_u,
  input  wire logic [2:0]             in_power_of_v,
  input  wire logic [63:0]            in_coef_value,
  input  wire logic [63:0]            in_x,
  input  wire logic [63:0]            in_y,
  input  wire sdp_pkg::sdp_cmd_t      cmd,
  output logic                        fpu_done,
  output logic [63:0]                 out_x,
  output logic [63:0]                 out_y
);
  import sdp_pkg::*;

  logic [63:0] ref_x_r, ref_y_r;
  logic [63:0] x_r, y_r, u_r, v_r, plu_r, plv_r, t_r, acc_r, xo_r, yo_r;
  logic [63:0] out_x_r, out_y_r;
  logic [63:0] pu_r [1:MAX_ORDER];
  logic [63:0] pv_r [1:MAX_ORDER];
  logic [63:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [63:0] rd_r;
  logic        rdv_r;

  // Reference pixel registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= 64'd0;
      ref_y_r <= 64'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_REF_X) ref_x_r <= cfg_data;
      if (cfg_index == CFG_REF_Y) ref_y_r <= cfg_data;
    end
  end

  // Coefficient write decode
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  always_comb begin
    wr_en   = in_fire && (in_operation == OP_WRITE) &&
              (int'(in_power_of_u) <= MAX_ORDER) && (int'(in_power_of_v) <= MAX_ORDER);
    wr_addr = {in_table_select, IDX_W'(in_power_of_u), IDX_W'(in_power_of_v)};
    rd_addr = {cmd.dir, cmd.tbl, cmd.i, cmd.j};
  end

  // Coefficient memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_coef_value;
    rd_r <= mem[rd_addr];
  end

  // Per-entry valid bits; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rdv_r   <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      rdv_r <= valid_r[rd_addr];
    end
  end

  // Operand selection per step
  logic [1:0]  fop;
  logic [63:0] opa, opb, coef, pu_sel, pv_sel, fres;

  always_comb begin
    coef   = rdv_r ? rd_r : 64'd0;
    pu_sel = (cmd.i == '0) ? FP_ONE : pu_r[cmd.i];
    pv_sel = (cmd.j == '0) ? FP_ONE : pv_r[cmd.j];
    fop    = FOP_MUL;
    opa    = t_r;
    opb    = pv_sel;
    case (cmd.step)
      ST_U:   begin fop = FOP_SUB; opa = x_r;   opb = ref_x_r; end
      ST_V:   begin fop = FOP_SUB; opa = y_r;   opb = ref_y_r; end
      ST_PU:  begin fop = FOP_MUL; opa = plu_r; opb = u_r;     end
      ST_PV:  begin fop = FOP_MUL; opa = plv_r; opb = v_r;     end
      ST_MC:  begin fop = FOP_MUL; opa = coef;  opb = pu_sel;  end
      ST_MV:  begin fop = FOP_MUL; opa = t_r;   opb = pv_sel;  end
      ST_ACC: begin fop = FOP_ADD; opa = acc_r; opb = t_r;     end
      default: begin
        fop = FOP_ADD;
        opa = cmd.tbl ? y_r : x_r;
        opb = acc_r;
      end
    endcase
  end

  sdp_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .fop   (fop),
    .a     (opa),
    .b     (opb),
    .done  (fpu_done),
    .res   (fres)
  );

  // Input coordinate capture and result write-back
  always_ff @(posedge clk) begin
    if (in_fire && ((in_operation == OP_FWD) || (in_operation == OP_REV))) begin
      x_r <= in_x;
      y_r <= in_y;
    end
    if (cmd.acc_clr) acc_r <= 64'd0;
    if (cmd.out_load) begin
      out_x_r <= xo_r;
      out_y_r <= yo_r;
    end
    if (fpu_done) begin
      case (cmd.step)
        ST_U:   begin u_r <= fres; plu_r <= FP_ONE; end
        ST_V:   begin v_r <= fres; plv_r <= FP_ONE; end
        ST_PU:  begin pu_r[cmd.k] <= fres; plu_r <= fres; end
        ST_PV:  begin pv_r[cmd.k] <= fres; plv_r <= fres; end
        ST_MC:  t_r <= fres;
        ST_MV:  t_r <= fres;
        ST_ACC: acc_r <= fres;
        default: begin
          if (cmd.tbl) yo_r <= fres;
          else xo_r <= fres;
        end
      endcase
    end
  end

  assign out_x = out_x_r;
  assign out_y = out_y_r;

endmodule
`default_nettype wire

FILE: rtl/core/sdp_ctrl.sv
// Controller: sequences the subtract, power, term and sum steps of one
// evaluate item and runs the channel handshakes. Depends on sdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdp_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [sdp_pkg::CFG_W-1:0] cfg_index,
  input  wire logic [63:0]               cfg_data,
  input  wire logic                      in_valid,
  input  wire logic [1:0]                in_operation,
  output logic                           in_ready,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  input  wire logic                      fpu_done,
  output sdp_pkg::sdp_cmd_t              cmd
);
  import sdp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(MAX_ORDER);
  localparam logic [IDX_W-1:0] K_ONE  = IDX_W'(1);

  logic [2:0]         state_r, state_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic               dir_r, dir_nxt, tbl_r, tbl_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ORDER_W-1:0] order_r [4];
  logic               acc_clr, out_load;

  // Order registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 4; n++) order_r[n] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FWD_X: order_r[0] <= cfg_data[ORDER_W-1:0];
        CFG_FWD_Y: order_r[1] <= cfg_data[ORDER_W-1:0];
        CFG_REV_X: order_r[2] <= cfg_data[ORDER_W-1:0];
        CFG_REV_Y: order_r[3] <= cfg_data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Order of the table in use, limited to the table size
  logic [ORDER_W-1:0] ord_raw;
  logic [IDX_W-1:0]   ord;

  always_comb begin
    ord_raw = order_r[{dir_r, tbl_r}];
    if (int'(ord_raw) > MAX_ORDER) ord = IDX_W'(MAX_ORDER);
    else ord = IDX_W'(ord_raw);
  end

  // Step sequencing
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    dir_nxt       = dir_r;
    tbl_nxt       = tbl_r;
    out_valid_nxt = out_valid_r;
    acc_clr       = 1'b0;
    out_load      = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && ((in_operation == OP_FWD) || (in_operation == OP_REV))) begin
          state_nxt = S_READ;
          step_nxt  = ST_U;
          dir_nxt   = in_operation == OP_REV;
          tbl_nxt   = 1'b0;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = K_ONE;
        end
      end
      S_READ:  state_nxt = S_ISSUE;
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (fpu_done) begin
          state_nxt = S_READ;
          case (step_r)
            ST_U: step_nxt = ST_V;
            ST_V: begin step_nxt = ST_PU; k_nxt = K_ONE; end
            ST_PU: begin
              if (k_r == K_LAST) begin
                step_nxt = ST_PV;
                k_nxt    = K_ONE;
              end else begin
                k_nxt = k_r + K_ONE;
              end
            end
            ST_PV: begin
              if (k_r == K_LAST) begin
                step_nxt = ST_MC;
                acc_clr  = 1'b1;
              end else begin
                k_nxt = k_r + K_ONE;
              end
            end
            ST_MC: step_nxt = ST_MV;
            ST_MV: step_nxt = ST_ACC;
            ST_ACC: begin
              if (j_r != ord) begin
                j_nxt    = j_r + K_ONE;
                step_nxt = ST_MC;
              end else if (i_r != ord) begin
                i_nxt    = i_r + K_ONE;
                j_nxt    = '0;
                step_nxt = ST_MC;
              end else begin
                step_nxt = ST_FIN;
              end
            end
            default: begin
              if (!tbl_r) begin
                tbl_nxt  = 1'b1;
                i_nxt    = '0;
                j_nxt    = '0;
                step_nxt = ST_MC;
                acc_clr  = 1'b1;
              end else begin
                state_nxt = S_PUSH;
              end
            end
          endcase
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    dir_r  <= dir_nxt;
    tbl_r  <= tbl_nxt;
  end

  always_comb begin
    cmd.start    = state_r == S_ISSUE;
    cmd.step     = step_r;
    cmd.i        = i_r;
    cmd.j        = j_r;
    cmd.k        = k_r;
    cmd.dir      = dir_r;
    cmd.tbl      = tbl_r;
    cmd.acc_clr  = acc_clr;
    cmd.out_load = out_load;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: rtl/core/sip_distortion_polynomial_unit.sv
// SIP distortion polynomial unit, top level. Depends on sdp_pkg, sdp_ifs,
// sdp_ctrl and sdp_dpath.
// An evaluate item runs 16 + 6*(n+1)^2 + 2 operations through the one shared
// binary64 unit (n = table order, where both tables in use have the same order);
// an operation lasts longest when the normalize loop runs on subnormal
// operands. One item is in work at a time. Reset (synchronous, active low)
// clears the control and configuration registers and the coefficient valid
// bits, so the coefficient tables read as zero.
`timescale 1ns / 1ps
`default_nettype none
module sip_distortion_polynomial_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [sdp_pkg::CFG_W-1:0] cfg_index,
  input  wire logic [63:0]               cfg_data,
  sdp_in_if.sink                         in_ch,
  sdp_out_if.source                      out_ch
);
  import sdp_pkg::*;

  sdp_cmd_t cmd;
  logic     fpu_done;
  logic     in_fire;

  assign in_fire = in_ch.valid & in_ch.ready;

  sdp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .fpu_done     (fpu_done),
    .cmd          (cmd)
  );

  sdp_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_fire         (in_fire),
    .in_operation    (in_ch.operation),
    .in_table_select (in_ch.table_select),
    .in_power_of_u   (in_ch.power_of_u),
    .in_power_of_v   (in_ch.power_of_v),
    .in_coef_value   (in_ch.coef_value),
    .in_x            (in_ch.x_in),
    .in_y            (in_ch.y_in),
    .cmd             (cmd),
    .fpu_done        (fpu_done),
    .out_x           (out_ch.x_out),
    .out_y           (out_ch.y_out)
  );

endmodule
`default_nettype wire

FILE: rtl/core/sdp_checker.sv
// Port-level checks for the SIP distortion polynomial unit, with its bind.
// Depends on sdp_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none
module sdp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_operation,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_x,
  input wire logic [63:0] out_y
);
  import sdp_pkg::*;

  // A result is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Once an evaluate item is accepted, the input is closed.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_FWD || in_operation == OP_REV)
      |=> !in_ready)
    else $error("input open during evaluation");

endmodule

bind sip_distortion_polynomial_unit sdp_checker u_sdp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_x        (out_ch.x_out),
  .out_y        (out_ch.y_out)
);
`default_nettype wire

FILE: verif/sip_distortion_polynomial_unit_test.sv
// Self-checking testbench for the SIP distortion polynomial unit: coefficient
// writes and forward and reverse evaluations, checked against a binary64 predictor.
// Depends on sdp_pkg, sdp_ifs and the sip_distortion_polynomial_unit RTL.
`timescale 1ns / 1ps
module sip_distortion_polynomial_unit_test;
  import sdp_pkg::*;

  typedef struct {
    logic [63:0] x_out;
    logic [63:0] y_out;
  } xy_pair_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_index;
  logic [63:0]       cfg_data;

  sdp_in_if  in_ch();
  sdp_out_if out_ch();

  sip_distortion_polynomial_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Predictor state: coefficient tables, reference pixel and table orders.
  logic [63:0] coef_store [4][DIM][DIM];
  logic [63:0] ref_x_bits;
  logic [63:0] ref_y_bits;
  logic [2:0]  table_order [4];

  xy_pair_t expected_xy[$];
  int       fail_count;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_request;
  int       hold_left;

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run limit.
  initial begin
    #100ms;
    $display("sip_distortion_polynomial_unit_test failed");
    $finish;
  end

  // Sum of coef[i][j] * u^i * v^j in loop order, powers by repeated multiply.
  function automatic real poly_sum(int tbl, real u, real v);
    real pu[DIM];
    real pv[DIM];
    real acc;
    real term;
    int  ord;
    ord = table_order[tbl];
    if (ord > MAX_ORDER) ord = MAX_ORDER;
    pu[0] = 1.0;
    pv[0] = 1.0;
    for (int k = 1; k < DIM; k++) begin
      pu[k] = pu[k-1] * u;
      pv[k] = pv[k-1] * v;
    end
    acc = 0.0;
    for (int i = 0; i <= ord; i++) begin
      for (int j = 0; j <= ord; j++) begin
        term = $bitstoreal(coef_store[tbl][i][j]) * pu[i];
        term = term * pv[j];
        acc  = acc + term;
      end
    end
    return acc;
  endfunction

  function automatic xy_pair_t distort_point(logic [1:0] op, logic [63:0] xb,
                                             logic [63:0] yb);
    xy_pair_t r;
    real x;
    real y;
    real u;
    real v;
    int  base;
    x = $bitstoreal(xb);
    y = $bitstoreal(yb);
    u = x - $bitstoreal(ref_x_bits);
    v = y - $bitstoreal(ref_y_bits);
    base = (op == OP_FWD) ? 0 : 2;
    r.x_out = $realtobits(x + poly_sum(base, u, v));
    r.y_out = $realtobits(y + poly_sum(base + 1, u, v));
    return r;
  endfunction

  function automatic bit is_nan(logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 0);
  endfunction

  // NaN payloads depend on the arithmetic unit, so any NaN matches a NaN.
  function automatic bit same_value(logic [63:0] e, logic [63:0] a);
    if (is_nan(e)) return is_nan(a);
    return e === a;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    xy_pair_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_xy.size() == 0) begin
        $error("result item with nothing expected: x_out %h y_out %h",
               out_ch.x_out, out_ch.y_out);
        fail_count++;
      end else begin
        e = expected_xy.pop_front();
        if (!same_value(e.x_out, out_ch.x_out)) begin
          $error("x_out expected %h actual %h", e.x_out, out_ch.x_out);
          fail_count++;
        end
        if (!same_value(e.y_out, out_ch.y_out)) begin
          $error("y_out expected %h actual %h", e.y_out, out_ch.y_out);
          fail_count++;
        end
      end
    end
  end

  // Result receiver: random stalls, and long hold-offs on request.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one item; valid stays high afterward so back-to-back items need no dip.
  task automatic send_item(logic [1:0] op, logic [1:0] tbl, logic [2:0] pu,
                           logic [2:0] pv, logic [63:0] coef, logic [63:0] xb,
                           logic [63:0] yb);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.operation    = op;
    in_ch.table_select = tbl;
    in_ch.power_of_u   = pu;
    in_ch.power_of_v   = pv;
    in_ch.coef_value   = coef;
    in_ch.x_in         = xb;
    in_ch.y_in         = yb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_WRITE) coef_store[tbl][pu][pv] = coef;
    else if (op == OP_FWD || op == OP_REV) expected_xy.push_back(distort_point(op, xb, yb));
  endtask

  task automatic write_coef(logic [1:0] tbl, logic [2:0] i, logic [2:0] j, real c);
    send_item(OP_WRITE, tbl, i, j, $realtobits(c), {$urandom, $urandom},
              {$urandom, $urandom});
  endtask

  task automatic evaluate(logic [1:0] op, logic [63:0] xb, logic [63:0] yb);
    send_item(op, $urandom, $urandom, $urandom, {$urandom, $urandom}, xb, yb);
  endtask

  // Drop valid, then wait until every expected result has arrived.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_xy.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(logic [CFG_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      CFG_REF_X: ref_x_bits = data;
      CFG_REF_Y: ref_y_bits = data;
      CFG_FWD_X: table_order[0] = data[2:0];
      CFG_FWD_Y: table_order[1] = data[2:0];
      CFG_REV_X: table_order[2] = data[2:0];
      CFG_REV_Y: table_order[3] = data[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_orders(int fx, int fy, int rx, int ry);
    write_reg(CFG_FWD_X, 64'(fx) | ({$urandom, $urandom} & ~64'h7));
    write_reg(CFG_FWD_Y, 64'(fy));
    write_reg(CFG_REV_X, 64'(rx));
    write_reg(CFG_REV_Y, 64'(ry));
  endtask

  // Mostly pixel-like coordinates, some raw patterns and special values.
  function automatic logic [63:0] rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 75)
      return $realtobits($itor($urandom_range(4096)) - 512.0 +
                         $itor($urandom) / 4294967296.0);
    if (sel < 88) return {$urandom, $urandom};
    case ($urandom_range(6))
      0: return 64'h0;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h7FF0_0000_0000_0000;
      3: return 64'hFFF0_0000_0000_0000;
      4: return 64'h7FF8_0000_0000_0001;
      5: return 64'h0000_0000_0000_0001;
      default: return 64'h7FEF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  // Distortion coefficients shrink with the power of u passed in, as real ones do.
  function automatic real rand_coef(int deg);
    real c;
    c = ($itor($urandom) / 4294967296.0 - 0.5) * 0.2;
    repeat (deg) c = c * 1.0e-3;
    return c;
  endfunction

  task automatic test_reset_state();
    evaluate(OP_FWD, $realtobits(12.5), $realtobits(-3.25));
    evaluate(OP_REV, rand_coord(), rand_coord());
    drain();
  endtask

  task automatic test_directed();
    write_reg(CFG_REF_X, $realtobits(512.0));
    write_reg(CFG_REF_Y, $realtobits(256.5));
    write_reg(3'd6, {$urandom, $urandom});
    write_reg(3'd7, {$urandom, $urandom});
    set_orders(MAX_ORDER, MAX_ORDER, 1, 0);
    for (int t = 0; t < 4; t++) begin
      write_coef(t, 0, 0, 0.5 + t);
      write_coef(t, MAX_ORDER, MAX_ORDER, 1.0e-20);
      write_coef(t, 1, 0, 1.0e-3);
    end
    write_coef(0, 0, 1, -2.0e-4);
    // The unused operation code is dropped without a result.
    send_item(2'd3, 2'd0, 3'd0, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1);
    evaluate(OP_FWD, $realtobits(600.0), $realtobits(100.0));
    evaluate(OP_REV, $realtobits(600.0), $realtobits(100.0));
    evaluate(OP_FWD, 64'h7FF8_0000_0000_0000, $realtobits(1.0));
    evaluate(OP_REV, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
    evaluate(OP_REV, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
    drain();
    write_reg(CFG_REF_X, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_REF_Y, 64'h0);
    set_orders(0, 0, 0, 0);
    evaluate(OP_FWD, rand_coord(), rand_coord());
    drain();
  endtask

  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    int done;
    int phase_len;
    int sel;
    int big;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < n_items) begin
      // New settings for each phase; the largest order gets short phases.
      big = ($urandom_range(9) == 0);
      write_reg(CFG_REF_X, ($urandom_range(19) == 0) ? {$urandom, $urandom} :
                $realtobits($itor($urandom_range(2048))));
      write_reg(CFG_REF_Y, ($urandom_range(19) == 0) ? {$urandom, $urandom} :
                $realtobits($itor($urandom_range(2048)) + 0.5));
      set_orders(big ? MAX_ORDER : $urandom_range(2), $urandom_range(2),
                 $urandom_range(2), big ? MAX_ORDER : $urandom_range(1));
      phase_len = big ? 12 : 60;
      for (int k = 0; k < phase_len; k++) begin
        sel = $urandom_range(99);
        if (sel < 50) begin
          sel = $urandom_range(DIM - 1);
          write_coef($urandom, sel, $urandom_range(DIM - 1), rand_coef(sel));
        end else if (sel < 57) begin
          send_item(OP_WRITE, $urandom, $urandom, $urandom, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        end else if (sel < 95) begin
          evaluate($urandom_range(1) ? OP_FWD : OP_REV, rand_coord(), rand_coord());
        end else begin
          send_item(2'd3, $urandom, $urandom, $urandom, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        end
      end
      done += phase_len;
      drain();
    end
  endtask

  task automatic test_back_pressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_orders(0, 0, 0, 0);
    hold_request = 4000;
    for (int k = 0; k < 8; k++) begin
      evaluate(k[0] ? OP_FWD : OP_REV, rand_coord(), rand_coord());
      write_coef($urandom, 0, 0, rand_coef(0));
    end
    // The sender pauses here until the last result is back.
    drain();
  endtask

  initial begin
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_WRITE;
    in_ch.table_select = '0;
    in_ch.power_of_u   = '0;
    in_ch.power_of_v   = '0;
    in_ch.coef_value   = '0;
    in_ch.x_in         = '0;
    in_ch.y_in         = '0;
    out_ch.ready       = 1'b0;
    ref_x_bits = '0;
    ref_y_bits = '0;
    for (int t = 0; t < 4; t++) begin
      table_order[t] = '0;
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++) coef_store[t][i][j] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed();
    test_random(620, 32, 55);
    test_random(620, 55, 32);
    test_back_pressure();
    test_random(620, 0, 0);

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("sip_distortion_polynomial_unit_test passed");
    end else begin
      $display("sip_distortion_polynomial_unit_test failed");
    end
    $finish;
  end
endmodule

FILE: sip_distortion_polynomial_unit.f
rtl/core/sdp_pkg.sv
rtl/core/sdp_ifs.sv
rtl/core/sdp_fpu.sv
rtl/core/sdp_dpath.sv
rtl/core/sdp_ctrl.sv
rtl/core/sip_distortion_polynomial_unit.sv
rtl/core/sdp_checker.sv
verif/sip_distortion_polynomial_unit_test.sv
